/* design/cks_pkg.sv */
// Shared types, constants and functions for the ChaCha20 keystream block generator.
// Holds the block constants, register indexes, job and state types, and the quarter-round step.
// No dependencies.
package cks_pkg;

    localparam int BLOCKS_DEF  = 8;
    localparam int BLK_W       = 3;
    localparam int WORD_W      = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int QDEPTH      = 2;
    // 20 rounds, two half quarter-rounds each
    localparam int ROUND_STEPS = 40;
    localparam int STEP_W      = $clog2(ROUND_STEPS);

    localparam logic [31:0] SIGMA0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA1 = 32'h3320_646e;
    localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
    localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY01   = 3'd0,
        CFG_KEY23   = 3'd1,
        CFG_KEY45   = 3'd2,
        CFG_KEY67   = 3'd3,
        CFG_NONCE01 = 3'd4,
        CFG_NONCE2  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [63:0] key01;
        logic [63:0] key23;
        logic [63:0] key45;
        logic [63:0] key67;
        logic [63:0] nonce01;
        logic [31:0] nonce2;
    } t_cfg;

    typedef struct packed {
        logic [31:0]      ctr;
        logic [BLK_W-1:0] blk;
        logic             last;
    } t_job;

    typedef struct packed {
        logic [BLK_W-1:0] blk;
        logic             last;
    } t_tag;

    typedef logic [15:0][31:0] t_state;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    // One half of a quarter round: two add, xor, rotate lines. Returns {a, b, c, d}.
    function automatic logic [127:0] qr_half(
        input logic [31:0] a,
        input logic [31:0] b,
        input logic [31:0] c,
        input logic [31:0] d,
        input logic        second
    );
        logic [31:0] na, nb, nc, nd;
        na = a + b;
        nd = second ? rotl(d ^ na, 8) : rotl(d ^ na, 16);
        nc = c + nd;
        nb = second ? rotl(b ^ nc, 7) : rotl(b ^ nc, 12);
        return {na, nb, nc, nd};
    endfunction

    function automatic t_state init_state(input t_cfg cfg, input logic [31:0] ctr);
        t_state s;
        s[0]  = SIGMA0;
        s[1]  = SIGMA1;
        s[2]  = SIGMA2;
        s[3]  = SIGMA3;
        s[4]  = cfg.key01[31:0];
        s[5]  = cfg.key01[63:32];
        s[6]  = cfg.key23[31:0];
        s[7]  = cfg.key23[63:32];
        s[8]  = cfg.key45[31:0];
        s[9]  = cfg.key45[63:32];
        s[10] = cfg.key67[31:0];
        s[11] = cfg.key67[63:32];
        s[12] = ctr;
        s[13] = cfg.nonce01[31:0];
        s[14] = cfg.nonce01[63:32];
        s[15] = cfg.nonce2;
        return s;
    endfunction

endpackage

/* design/cks_front.sv */
// Front end: accepts a start counter and expands it into one job per block of the batch.
// Depends on cks_pkg.
module cks_front import cks_pkg::*; #(
    parameter int BLOCKS = BLOCKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_start_counter,
    output logic        o_push,
    output t_job        o_job,
    input  logic        i_full
);

    localparam int NBLK = (BLOCKS < 1) ? 1 : ((BLOCKS > 8) ? 8 : BLOCKS);
    localparam logic [BLK_W-1:0] LAST_BLK = BLK_W'(NBLK - 1);

    logic             r_busy, n_busy;
    logic [31:0]      r_ctr, n_ctr;
    logic [BLK_W-1:0] r_blk, n_blk;

    assign o_stall = r_busy;
    assign o_push  = r_busy && !i_full;

    assign o_job.ctr  = r_ctr + {{(32-BLK_W){1'b0}}, r_blk};
    assign o_job.blk  = r_blk;
    assign o_job.last = (r_blk == LAST_BLK);

    always_comb begin
        n_busy = r_busy;
        n_ctr  = r_ctr;
        n_blk  = r_blk;
        if (!r_busy && i_valid) begin
            n_busy = 1'b1;
            n_ctr  = i_start_counter;
            n_blk  = '0;
        end else if (o_push) begin
            if (r_blk == LAST_BLK) begin
                n_busy = 1'b0;
            end else begin
                n_blk = r_blk + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_blk  <= '0;
        end else begin
            r_busy <= n_busy;
            r_blk  <= n_blk;
        end
        r_ctr <= n_ctr;
    end

endmodule

/* design/cks_queue.sv */
// Short job queue between the front end and the round engine.
// Depends on cks_pkg.
module cks_queue import cks_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    output t_job o_job,
    input  logic i_pop
);

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QDEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QDEPTH - 1);

    t_job             r_mem [QDEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

/* design/cks_rounds.sv */
// Round engine: runs 20 ChaCha rounds on one block, two half quarter-rounds per round,
// four lanes in parallel, then offers the state plus the initial state. Depends on cks_pkg.
module cks_rounds import cks_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    input  logic   i_job_valid,
    input  t_job   i_job,
    output logic   o_pop,
    output logic   o_res_valid,
    output t_state o_res,
    output t_tag   o_tag,
    input  logic   i_res_take
);

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ROUND_STEPS - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_rstate;

    t_rstate           r_state, n_state;
    t_state            r_x, n_x;
    logic [31:0]       r_ctr;
    t_tag              r_tag;
    logic [STEP_W-1:0] r_step, n_step;
    t_state            w_init, w_col, w_dia;
    logic [3:0][127:0] w_qc, w_qd;

    assign w_init      = init_state(i_cfg, r_ctr);
    assign o_res_valid = (r_state == S_DONE);
    assign o_tag       = r_tag;
    assign o_pop       = i_job_valid &&
                         ((r_state == S_IDLE) || ((r_state == S_DONE) && i_res_take));

    always_comb begin
        for (int k = 0; k < 16; k++) begin
            o_res[k] = r_x[k] + w_init[k];
        end
    end

    // Column lanes take (i, 4+i, 8+i, 12+i); diagonal lanes rotate the lower three rows.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_qc[i] = qr_half(r_x[i], r_x[4+i], r_x[8+i], r_x[12+i], r_step[0]);
            w_qd[i] = qr_half(r_x[i], r_x[4+((i+1)%4)], r_x[8+((i+2)%4)],
                              r_x[12+((i+3)%4)], r_step[0]);
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_col[i]    = w_qc[i][127:96];
            w_col[4+i]  = w_qc[i][95:64];
            w_col[8+i]  = w_qc[i][63:32];
            w_col[12+i] = w_qc[i][31:0];
            w_dia[i]              = w_qd[i][127:96];
            w_dia[4+((i+1)%4)]    = w_qd[i][95:64];
            w_dia[8+((i+2)%4)]    = w_qd[i][63:32];
            w_dia[12+((i+3)%4)]   = w_qd[i][31:0];
        end
    end

    always_comb begin
        n_state = r_state;
        n_x     = r_x;
        n_step  = r_step;
        case (r_state)
            S_IDLE: begin
                n_state = r_state;
            end
            S_RUN: begin
                n_x    = r_step[1] ? w_dia : w_col;
                n_step = r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // start the next block as soon as the engine frees up
        if (o_pop) begin
            n_state = S_RUN;
            n_x     = init_state(i_cfg, i_job.ctr);
            n_step  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
        r_x <= n_x;
        if (o_pop) begin
            r_ctr     <= i_job.ctr;
            r_tag.blk  <= i_job.blk;
            r_tag.last <= i_job.last;
        end
    end

endmodule

/* design/cks_emit.sv */
// Output stage: holds one finished block and sends it out as eight 64-bit words.
// Depends on cks_pkg.
module cks_emit import cks_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_res_valid,
    input  t_state            i_res,
    input  t_tag              i_tag,
    output logic              o_res_take,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [BLK_W-1:0]  o_block_index,
    output logic [WORD_W-1:0] o_word_index,
    output logic [63:0]       o_keystream_data,
    output logic              o_last_word
);

    localparam logic [WORD_W-1:0] LAST_WORD = '1;

    logic [7:0][63:0]  r_buf;
    logic              r_full;
    logic [WORD_W-1:0] r_word;
    t_tag              r_tag;
    logic              w_send;

    assign w_send     = r_full && !i_stall;
    assign o_res_take = i_res_valid && (!r_full || (w_send && (r_word == LAST_WORD)));

    assign o_valid          = r_full;
    assign o_block_index    = r_tag.blk;
    assign o_word_index     = r_word;
    assign o_keystream_data = r_buf[r_word];
    assign o_last_word      = r_tag.last && (r_word == LAST_WORD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_word <= '0;
        end else begin
            if (o_res_take) begin
                r_full <= 1'b1;
                r_word <= '0;
            end else if (w_send) begin
                if (r_word == LAST_WORD) begin
                    r_full <= 1'b0;
                end
                r_word <= r_word + 1'b1;
            end
        end
        if (o_res_take) begin
            r_tag <= i_tag;
            for (int j = 0; j < 8; j++) begin
                r_buf[j] <= {i_res[2*j+1], i_res[2*j]};
            end
        end
    end

endmodule

/* design/chacha20_keystream_blocks_top.sv */
// ChaCha20 keystream generator: BLOCKS consecutive 64-byte blocks per start counter.
// The round engine works on one block at a time in 40 steps; words leave at one per cycle
// unless i_stall holds them, while the next block is computed.
// Reset (synchronous, active low) clears key, nonce, queue and all handshake state.
// Depends on cks_pkg, cks_front, cks_queue, cks_rounds and cks_emit.
module chacha20_keystream_blocks_top import cks_pkg::*; #(
    parameter int BLOCKS = BLOCKS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [31:0]           i_start_counter,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [BLK_W-1:0]      o_block_index,
    output logic [WORD_W-1:0]     o_word_index,
    output logic [63:0]           o_keystream_data,
    output logic                  o_last_word
);

    t_cfg   r_cfg;
    logic   w_push, w_full, w_qvalid, w_pop;
    t_job   w_push_job, w_q_job;
    logic   w_res_valid, w_res_take;
    t_state w_res;
    t_tag   w_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_KEY01:   r_cfg.key01   <= i_cfg_data;
                CFG_KEY23:   r_cfg.key23   <= i_cfg_data;
                CFG_KEY45:   r_cfg.key45   <= i_cfg_data;
                CFG_KEY67:   r_cfg.key67   <= i_cfg_data;
                CFG_NONCE01: r_cfg.nonce01 <= i_cfg_data;
                CFG_NONCE2:  r_cfg.nonce2  <= i_cfg_data[31:0];
                default: begin
                    // drop writes to unknown indexes
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    cks_front #(
        .BLOCKS(BLOCKS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_start_counter (i_start_counter),
        .o_push          (w_push),
        .o_job           (w_push_job),
        .i_full          (w_full)
    );

    cks_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .o_valid (w_qvalid),
        .o_job   (w_q_job),
        .i_pop   (w_pop)
    );

    cks_rounds u_rounds (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (w_qvalid),
        .i_job       (w_q_job),
        .o_pop       (w_pop),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .o_tag       (w_tag),
        .i_res_take  (w_res_take)
    );

    cks_emit u_emit (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_res_valid      (w_res_valid),
        .i_res            (w_res),
        .i_tag            (w_tag),
        .o_res_take       (w_res_take),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_block_index    (o_block_index),
        .o_word_index     (o_word_index),
        .o_keystream_data (o_keystream_data),
        .o_last_word      (o_last_word)
    );

endmodule

/* tb/sv/chacha20_keystream_blocks_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for chacha20_keystream_blocks_top: computes each 64-word batch
// in a local block-function model and compares every output word in order.
// Depends on cks_pkg and the design files under design/.
module chacha20_keystream_blocks_top_tb;
    import cks_pkg::*;

    localparam int TB_BLOCKS      = BLOCKS_DEF;
    localparam int BATCH_BLOCKS   = (TB_BLOCKS < 1) ? 1 : ((TB_BLOCKS > 8) ? 8 : TB_BLOCKS);
    localparam int SETTLE_CYCLES  = 60;
    localparam int HOLD_CYCLES    = 1500;
    localparam int WATCHDOG_LIMIT = 8000;
    localparam int MAX_REPORTS    = 10;

    // register indexes past the end of the map: writes must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE7 = 3'd7;

    typedef enum int {FILL_RANDOM, FILL_ZEROS, FILL_ONES, FILL_STRIPES} t_cfg_fill;

    typedef logic [15:0][31:0] t_block_words;

    typedef struct packed {
        logic [BLK_W-1:0]  blk;
        logic [WORD_W-1:0] word;
        logic [63:0]       data;
        logic              last;
    } t_keystream_word;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_stall;
    logic [31:0]           i_start_counter;
    logic                  o_valid;
    logic                  i_stall;
    logic [BLK_W-1:0]      o_block_index;
    logic [WORD_W-1:0]     o_word_index;
    logic [63:0]           o_keystream_data;
    logic                  o_last_word;

    // shadow copy of the key and nonce registers
    logic [63:0] key_reg [4];
    logic [63:0] nonce01_reg;
    logic [31:0] nonce2_reg;

    t_keystream_word keystream_expected [$];
    int              fail_count  = 0;
    int              quiet_cycles = 0;
    int              hold_len    = 0;
    bit              tx_idle_on  = 1'b1;
    bit              rx_idle_on  = 1'b1;

    chacha20_keystream_blocks_top #(
        .BLOCKS(TB_BLOCKS)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_start_counter (i_start_counter),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_block_index   (o_block_index),
        .o_word_index    (o_word_index),
        .o_keystream_data(o_keystream_data),
        .o_last_word     (o_last_word)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [31:0] rol32(input logic [31:0] v, input int s);
        logic [63:0] twice;
        twice = {v, v} << s;
        return twice[63:32];
    endfunction

    function automatic t_block_words quarter_round(input t_block_words w,
                                                   input int a, input int b,
                                                   input int c, input int d);
        w[a] = w[a] + w[b]; w[d] = rol32(w[d] ^ w[a], 16);
        w[c] = w[c] + w[d]; w[b] = rol32(w[b] ^ w[c], 12);
        w[a] = w[a] + w[b]; w[d] = rol32(w[d] ^ w[a], 8);
        w[c] = w[c] + w[d]; w[b] = rol32(w[b] ^ w[c], 7);
        return w;
    endfunction

    function automatic t_block_words chacha_block(input logic [31:0] ctr);
        t_block_words init;
        t_block_words w;
        init[0]  = SIGMA0;
        init[1]  = SIGMA1;
        init[2]  = SIGMA2;
        init[3]  = SIGMA3;
        for (int k = 0; k < 4; k++) begin
            init[4 + 2 * k] = key_reg[k][31:0];
            init[5 + 2 * k] = key_reg[k][63:32];
        end
        init[12] = ctr;
        init[13] = nonce01_reg[31:0];
        init[14] = nonce01_reg[63:32];
        init[15] = nonce2_reg;
        w = init;
        for (int r = 0; r < 10; r++) begin
            w = quarter_round(w, 0, 4, 8, 12);
            w = quarter_round(w, 1, 5, 9, 13);
            w = quarter_round(w, 2, 6, 10, 14);
            w = quarter_round(w, 3, 7, 11, 15);
            w = quarter_round(w, 0, 5, 10, 15);
            w = quarter_round(w, 1, 6, 11, 12);
            w = quarter_round(w, 2, 7, 8, 13);
            w = quarter_round(w, 3, 4, 9, 14);
        end
        for (int i = 0; i < 16; i++)
            w[i] = w[i] + init[i];
        return w;
    endfunction

    function automatic void predict_batch(input logic [31:0] ctr);
        t_block_words    blk_words;
        t_keystream_word kw;
        for (int b = 0; b < BATCH_BLOCKS; b++) begin
            // counter wraps modulo 2^32 inside the batch
            blk_words = chacha_block(ctr + 32'(b));
            for (int j = 0; j < 8; j++) begin
                kw.blk  = BLK_W'(b);
                kw.word = WORD_W'(j);
                kw.data = {blk_words[2 * j + 1], blk_words[2 * j]};
                kw.last = (b == BATCH_BLOCKS - 1) && (j == 7);
                keystream_expected.push_back(kw);
            end
        end
    endfunction

    function automatic void report_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t: %s", $realtime, msg);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(30, 120);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_KEY01:   key_reg[0]  = data;
            CFG_KEY23:   key_reg[1]  = data;
            CFG_KEY45:   key_reg[2]  = data;
            CFG_KEY67:   key_reg[3]  = data;
            CFG_NONCE01: nonce01_reg = data;
            CFG_NONCE2:  nonce2_reg  = data[31:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic load_config(input t_cfg_fill fill);
        logic [63:0] val;
        for (int idx = 0; idx < 6; idx++) begin
            case (fill)
                FILL_ZEROS:   val = '0;
                FILL_ONES:    val = '1;
                FILL_STRIPES: val = idx[0] ? 64'h5555_5555_5555_5555 : 64'hAAAA_AAAA_AAAA_AAAA;
                default:      val = {$urandom, $urandom};
            endcase
            write_reg(CFG_IDX_W'(idx), val);
        end
    endtask

    // Offer one request and wait until it is taken; valid stays high on return.
    task automatic send_counter(input logic [31:0] ctr);
        int gap;
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_start_counter <= ctr;
        do
            @(posedge i_clk);
        while (o_stall);
        predict_batch(ctr);
    endtask

    task automatic end_stream();
        i_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (keystream_expected.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_zero_key();
        send_counter(32'h0000_0000);
        send_counter(32'h0000_0001);
        send_counter(32'hFFFF_FFFF);
        send_counter(32'hFFFF_FFFC);
        end_stream();
        wait_drained();
    endtask

    task automatic test_rfc_vector();
        write_reg(CFG_KEY01,   64'h0706_0504_0302_0100);
        write_reg(CFG_KEY23,   64'h0f0e_0d0c_0b0a_0908);
        write_reg(CFG_KEY45,   64'h1716_1514_1312_1110);
        write_reg(CFG_KEY67,   64'h1f1e_1d1c_1b1a_1918);
        write_reg(CFG_NONCE01, 64'h4a00_0000_0900_0000);
        write_reg(CFG_NONCE2,  64'h0);
        send_counter(32'h0000_0001);
        send_counter(32'h0000_0000);
        end_stream();
        wait_drained();
    endtask

    task automatic test_register_extremes();
        load_config(FILL_ONES);
        send_counter(32'h0000_0000);
        send_counter(32'hFFFF_FFFF);
        send_counter(32'h8000_0000);
        send_counter(32'h7FFF_FFFF);
        send_counter(32'hFFFF_FFF9);
        end_stream();
        wait_drained();
        // writes past the register map leave the key and nonce alone
        write_reg(CFG_SPARE6, {$urandom, $urandom});
        write_reg(CFG_SPARE7, {$urandom, $urandom});
        send_counter($urandom);
        send_counter(32'hFFFF_FFFE);
        end_stream();
        wait_drained();
        // upper half of the nonce word 2 write must be dropped
        write_reg(CFG_NONCE2, {$urandom | 32'h1, 32'h0});
        send_counter(32'h0000_0002);
        end_stream();
        wait_drained();
        load_config(FILL_STRIPES);
        send_counter(32'h5555_5555);
        send_counter(32'hAAAA_AAAA);
        end_stream();
        wait_drained();
    endtask

    task automatic test_random_batches();
        logic [31:0] ctr;
        int          r;
        for (int phase = 0; phase < 5; phase++) begin
            load_config(phase == 3 ? FILL_ZEROS : FILL_RANDOM);
            if ($urandom_range(0, 1))
                write_reg($urandom_range(0, 1) ? CFG_SPARE6 : CFG_SPARE7, {$urandom, $urandom});
            for (int n = 0; n < 90; n++) begin
                // every 30 requests, choose at random whether each side inserts idle gaps
                if (n % 30 == 0) begin
                    tx_idle_on = ($urandom_range(0, 3) != 0);
                    rx_idle_on = ($urandom_range(0, 3) != 0);
                end
                r = $urandom_range(0, 15);
                if (r < 2)
                    ctr = 32'hFFFF_FFFF - $urandom_range(0, 15);
                else if (r < 3)
                    ctr = $urandom_range(0, 15);
                else
                    ctr = $urandom;
                send_counter(ctr);
            end
            end_stream();
            wait_drained();
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_output_backpressure();
        load_config(FILL_RANDOM);
        tx_idle_on = 1'b0;
        hold_len   = HOLD_CYCLES;
        for (int n = 0; n < 12; n++)
            send_counter($urandom);
        end_stream();
        wait_drained();
        tx_idle_on = 1'b1;
        for (int n = 0; n < 20; n++)
            send_counter($urandom);
        end_stream();
        wait_drained();
    endtask

    // receiver: random stall runs, plus one long hold-off on request
    initial begin : receiver
        int run;
        i_stall <= 1'b0;
        forever begin
            if (hold_len > 0) begin
                run      = hold_len;
                hold_len = 0;
            end else begin
                run = ($urandom_range(0, 3) == 0 && rx_idle_on) ? pick_gap() : 0;
            end
            if (run > 0) begin
                i_stall <= 1'b1;
                repeat (run) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_keystream_word exp_word;
        if (i_rst_n && o_valid && !i_stall) begin
            if (keystream_expected.size() == 0) begin
                report_failure($sformatf("unexpected word: blk=%0d word=%0d data=%h last=%b",
                    o_block_index, o_word_index, o_keystream_data, o_last_word));
            end else begin
                exp_word = keystream_expected.pop_front();
                if (o_block_index !== exp_word.blk || o_word_index !== exp_word.word ||
                    o_keystream_data !== exp_word.data || o_last_word !== exp_word.last)
                    report_failure({
                        $sformatf("mismatch: exp blk=%0d word=%0d data=%h last=%b, ",
                            exp_word.blk, exp_word.word, exp_word.data, exp_word.last),
                        $sformatf("got blk=%0d word=%0d data=%h last=%b",
                            o_block_index, o_word_index, o_keystream_data, o_last_word)});
            end
        end
    end

    // watchdog: nothing moving on either side for too long means a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= '0;
        i_cfg_data      <= '0;
        i_valid         <= 1'b0;
        i_start_counter <= '0;
        for (int k = 0; k < 4; k++)
            key_reg[k] = '0;
        nonce01_reg = '0;
        nonce2_reg  = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_key();
        test_rfc_vector();
        test_register_extremes();
        test_random_batches();
        test_output_backpressure();

        if (keystream_expected.size() != 0)
            report_failure($sformatf("%0d words never arrived", keystream_expected.size()));
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
